[rtl/unique_value_set_table_macros.svh]
// assertion macros used by the set table checker
`ifndef UNIQUE_VALUE_SET_TABLE_MACROS_SVH
`define UNIQUE_VALUE_SET_TABLE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define UVST_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define UVST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/uvst_pkg.sv]
// types and codes of the unique value set table
`default_nettype none

package uvst_pkg;

    localparam int FUNC_W     = 2;
    localparam int VALUE_W    = 32;
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;
    localparam int COUNT_W    = 7;
    localparam int STATUS_W   = 2;

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

endpackage

`default_nettype wire

[rtl/unique_value_set_table.sv]
// unique value set table: packed store with linear search, one request at a time
// an accepted word is scanned against the live entries in order, stopping at a match;
//   the scan is skipped on an empty table
// the store's single read port gives one entry per cycle to the scan, and a new word
//   is taken only after the result of the last one has been loaded for output
// reset clears the live count, the control state and the output valid flag;
//   the store itself is not cleared, only entries below the live count are used
`default_nettype none

module unique_value_set_table #(
    parameter int CAPACITY   = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [uvst_pkg::S_TDATA_W-1:0]  s_tdata,   // value[31:0]
    input  wire logic [uvst_pkg::S_TUSER_W-1:0]  s_tuser,   // func[1:0]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [uvst_pkg::M_TDATA_W-1:0]       m_tdata    // ok, status[1:0],
                                                            // count[6:0], is_empty, zeros
);
    import uvst_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = (ELEM_WIDTH < VALUE_W) ? ELEM_WIDTH : VALUE_W;
    localparam int PAD_W = M_TDATA_W - 1 - STATUS_W - COUNT_W - 1;

    logic [ELEM_WIDTH-1:0] mem [CAPACITY];

    state_t                state_reg, state_next;
    logic [FUNC_W-1:0]     func_reg;
    logic [ELEM_WIDTH-1:0] key_reg;
    logic [IW-1:0]         idx_reg, idx_next;
    logic                  found_reg, found_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]  out_data_reg;
    logic [ELEM_WIDTH-1:0] rd_data_reg;

    logic [ELEM_WIDTH-1:0] key_in;
    logic [IW-1:0]         rd_addr;
    logic [IW-1:0]         last_idx;
    logic                  match;
    logic                  is_last;
    logic                  s_accept;
    logic                  out_free;
    logic                  load_out;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [ELEM_WIDTH-1:0] wr_data;
    logic                  res_ok;
    logic [STATUS_W-1:0]   res_status;

    assign key_in   = ELEM_WIDTH'(s_tdata[VW-1:0]);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign last_idx = IW'(count_reg - CW'(1));
    assign match    = (rd_data_reg == key_reg);
    assign is_last  = (CW'(idx_reg) == (count_reg - CW'(1)));

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        count_next = count_reg;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = count_reg[IW-1:0];
        wr_data    = key_reg;
        res_ok     = 1'b0;
        res_status = STATUS_ABSENT;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = (count_reg == '0) ? ST_APPLY : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (match) begin
                    // fetch the last live entry for a possible move on remove
                    found_next = 1'b1;
                    rd_addr    = last_idx;
                    state_next = ST_APPLY;
                end else if (is_last) begin
                    state_next = ST_APPLY;
                end else begin
                    idx_next = idx_reg + IW'(1);
                    rd_addr  = idx_reg + IW'(1);
                end
            end
            ST_APPLY: begin
                // keep the last live entry on the read port while the output stalls
                rd_addr = last_idx;
                case (func_reg)
                    FUNC_ADD: begin
                        if (found_reg) begin
                            res_status = STATUS_ABSENT;
                        end else if (count_reg == CW'(CAPACITY)) begin
                            res_status = STATUS_FULL;
                        end else begin
                            res_ok     = 1'b1;
                            res_status = STATUS_DONE;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (found_reg) begin
                            res_ok     = 1'b1;
                            res_status = STATUS_DONE;
                        end
                    end
                    default: begin
                        if (found_reg) begin
                            res_ok     = 1'b1;
                            res_status = STATUS_DONE;
                        end
                    end
                endcase
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    if (res_ok && func_reg == FUNC_ADD) begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[IW-1:0];
                        wr_data    = key_reg;
                        count_next = count_reg + CW'(1);
                    end else if (res_ok && func_reg == FUNC_REMOVE) begin
                        // last live entry fills the hole
                        wr_en      = 1'b1;
                        wr_addr    = idx_reg;
                        wr_data    = rd_data_reg;
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (s_accept) begin
            func_reg <= s_tuser;
            key_reg  <= key_in;
        end
        if (load_out) begin
            out_data_reg <= {{PAD_W{1'b0}}, (count_next == '0), COUNT_W'(count_next),
                             res_status, res_ok};
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

[rtl/uvst_checker.sv]
// port level checks for the unique value set table, bound to the top level
`default_nettype none

`include "unique_value_set_table_macros.svh"

module uvst_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [uvst_pkg::M_TDATA_W-1:0] m_tdata
);
    import uvst_pkg::*;

    logic                ok_bit;
    logic [STATUS_W-1:0] status_bits;
    logic [COUNT_W-1:0]  count_bits;
    logic                empty_bit;

    assign ok_bit      = m_tdata[0];
    assign status_bits = m_tdata[STATUS_W:1];
    assign count_bits  = m_tdata[STATUS_W+COUNT_W:STATUS_W+1];
    assign empty_bit   = m_tdata[STATUS_W+COUNT_W+1];

    // a stalled result word holds
    `UVST_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // one request at a time: busy right after taking a word
    `UVST_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready,
        !s_tready, "input taken again while a request is in progress")

    `UVST_ASSERT_NOW(a_ok_status, aclk, aresetn, m_tvalid,
        ok_bit == (status_bits == STATUS_DONE), "ok disagrees with status")

    `UVST_ASSERT_NOW(a_status_code, aclk, aresetn, m_tvalid,
        status_bits == STATUS_DONE || status_bits == STATUS_ABSENT ||
        status_bits == STATUS_FULL, "status code out of range")

    `UVST_ASSERT_NOW(a_empty_count, aclk, aresetn, m_tvalid && empty_bit,
        count_bits == '0, "empty flag set with a non-zero count")

endmodule

bind unique_value_set_table uvst_checker u_uvst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/sv/unique_value_set_table_tb.sv]
`timescale 1ns / 100ps
// testbench for the unique value set table: request streams checked against a model of the set
module unique_value_set_table_tb;
    import uvst_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int POOL_SIZE    = 96;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_WORDS  = 300;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    typedef struct packed {
        logic                ok;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                is_empty;
    } set_reply_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    unique_value_set_table uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // model of the set
    logic [VALUE_W-1:0] set_store [TABLE_DEPTH];
    int                 set_count = 0;
    set_reply_t         expected_replies [$];

    logic [VALUE_W-1:0] value_pool [POOL_SIZE];
    int mismatches      = 0;
    int words_sent      = 0;
    int replies_checked = 0;
    int full_refusals   = 0;
    int empty_replies   = 0;
    int quiet_cycles    = 0;
    int hold_request    = 0;
    bit send_gaps       = 1'b1;
    bit sink_gaps       = 1'b1;

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic set_reply_t predict_set_op(logic [FUNC_W-1:0] func,
                                                  logic [VALUE_W-1:0] value);
        set_reply_t reply;
        int         hit;
        hit = -1;
        for (int i = 0; i < set_count; i++) begin
            if (hit < 0 && set_store[i] == value) hit = i;
        end
        reply.ok     = 1'b0;
        reply.status = STATUS_ABSENT;
        if (func == FUNC_ADD) begin
            // presence is checked before capacity
            if (hit < 0 && set_count >= TABLE_DEPTH) begin
                reply.status = STATUS_FULL;
            end else if (hit < 0) begin
                set_store[set_count] = value;
                set_count++;
                reply.ok     = 1'b1;
                reply.status = STATUS_DONE;
            end
        end else if (func == FUNC_REMOVE) begin
            if (hit >= 0) begin
                set_store[hit] = set_store[set_count-1];
                set_count--;
                reply.ok     = 1'b1;
                reply.status = STATUS_DONE;
            end
        end else if (hit >= 0) begin
            // search, and the spare code decodes as search
            reply.ok     = 1'b1;
            reply.status = STATUS_DONE;
        end
        reply.count    = COUNT_W'(set_count);
        reply.is_empty = (set_count == 0);
        return reply;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return value_pool[$urandom_range(0, POOL_SIZE-1)];
        end else if (roll < 82) begin
            // one bit away from a likely entry
            return value_pool[$urandom_range(0, POOL_SIZE-1)]
                   ^ (32'h1 << $urandom_range(0, VALUE_W-1));
        end
        return $urandom;
    endfunction

    task automatic send_word(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value);
        int gap;
        set_reply_t reply;
        gap = send_gaps ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        reply = predict_set_op(func, value);
        if (reply.status == STATUS_FULL) full_refusals++;
        expected_replies.push_back(reply);
        words_sent++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic test_directed_cases();
        send_word(FUNC_SEARCH, 32'h0000_0000);
        send_word(FUNC_REMOVE, 32'h0000_0000);
        send_word(FUNC_SPARE,  32'h0000_0000);
        send_word(FUNC_ADD,    32'h0000_0000);
        send_word(FUNC_ADD,    32'h0000_0000);
        send_word(FUNC_ADD,    32'hFFFF_FFFF);
        send_word(FUNC_ADD,    32'h8000_0000);
        send_word(FUNC_ADD,    32'h7FFF_FFFF);
        send_word(FUNC_SEARCH, 32'h7FFF_FFFF);
        send_word(FUNC_SEARCH, 32'h8000_0001);
        send_word(FUNC_SPARE,  32'h8000_0000);
        // middle entry: the last one moves into its slot
        send_word(FUNC_REMOVE, 32'hFFFF_FFFF);
        send_word(FUNC_SEARCH, 32'h7FFF_FFFF);
        send_word(FUNC_REMOVE, 32'h7FFF_FFFF);
        send_word(FUNC_REMOVE, 32'h7FFF_FFFF);
        send_word(FUNC_REMOVE, 32'h8000_0000);
        send_word(FUNC_REMOVE, 32'h0000_0000);
        send_word(FUNC_ADD,    32'h0000_0000);
        send_word(FUNC_REMOVE, 32'h0000_0000);
    endtask

    task automatic test_fill_to_capacity();
        int i;
        i = 0;
        while (set_count < TABLE_DEPTH) begin
            send_word(FUNC_ADD, value_pool[i]);
            i++;
        end
        send_word(FUNC_ADD,    value_pool[POOL_SIZE-1]);
        send_word(FUNC_ADD,    value_pool[0]);
        send_word(FUNC_SEARCH, value_pool[TABLE_DEPTH-1]);
        send_word(FUNC_REMOVE, value_pool[0]);
        send_word(FUNC_ADD,    value_pool[POOL_SIZE-1]);
        send_word(FUNC_ADD,    value_pool[POOL_SIZE-2]);
        send_word(FUNC_REMOVE, value_pool[POOL_SIZE-1]);
        send_word(FUNC_SEARCH, value_pool[POOL_SIZE-1]);
    endtask

    task automatic test_output_hold_off();
        // sink stalls for a long stretch while words keep coming
        send_gaps    = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (24) begin
            send_word($urandom_range(0, 1) ? FUNC_SEARCH : FUNC_ADD, pick_value());
        end
        send_gaps = 1'b1;
    endtask

    task automatic test_random_mix();
        int add_pct [6];
        int rem_pct [6];
        int roll;
        logic [FUNC_W-1:0] func;
        add_pct = '{40, 70, 15, 40, 60, 20};
        rem_pct = '{30, 10, 60, 40, 15, 50};
        for (int phase = 0; phase < 6; phase++) begin
            send_gaps = (phase % 3) != 0;
            sink_gaps = (phase % 3) == 2;
            repeat (PHASE_WORDS) begin
                roll = $urandom_range(0, 99);
                if (roll < add_pct[phase]) begin
                    func = FUNC_ADD;
                end else if (roll < add_pct[phase] + rem_pct[phase]) begin
                    func = FUNC_REMOVE;
                end else begin
                    func = ($urandom_range(0, 9) == 0) ? FUNC_SPARE : FUNC_SEARCH;
                end
                send_word(func, pick_value());
            end
        end
        send_gaps = 1'b1;
        sink_gaps = 1'b1;
    endtask

    // result side: draws a stall before each word, or takes a requested hold-off
    initial begin : sink
        int stall;
        wait (aresetn);
        forever begin
            stall = sink_gaps ? $urandom_range(0, 14) : 0;
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin : reply_check
        set_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: word %h arrived with no request pending", $time, m_tdata);
                mismatches++;
            end else begin
                want = expected_replies.pop_front();
                check_field("ok",       want.ok,       m_tdata[0]);
                check_field("status",   want.status,   m_tdata[2:1]);
                check_field("count",    want.count,    m_tdata[9:3]);
                check_field("is_empty", want.is_empty, m_tdata[10]);
                replies_checked++;
                if (m_tdata[10]) empty_replies++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : main
        logic [VALUE_W-1:0] v;
        bit clash;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++) begin
            do begin
                v     = $urandom;
                clash = 1'b0;
                for (int j = 0; j < i; j++) begin
                    if (value_pool[j] == v) clash = 1'b1;
                end
            end while (clash);
            value_pool[i] = v;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_fill_to_capacity();
        test_output_hold_off();
        test_random_mix();
        s_tvalid <= 1'b0;

        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests sent, %0d replies checked", words_sent, replies_checked);
        $display("adds refused on a full table: %0d, replies with the table empty: %0d",
                 full_refusals, empty_replies);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[unique_value_set_table.f]
+incdir+rtl
rtl/uvst_pkg.sv
rtl/unique_value_set_table.sv
rtl/uvst_checker.sv
tb/sv/unique_value_set_table_tb.sv
